/* hw/rtl/fnc_pkg.sv */
// Shared types, constants and helper functions for the FAT file name checker.
package fnc_pkg;

    // Name length limit and derived field widths
    localparam int MAX_NAME_LEN_DEF = 255;
    localparam int CH_W             = 8;
    localparam int ENT_W            = 5;
    localparam int BASE_W           = 4;
    localparam int EXT_W            = 3;
    localparam int PREFIX_W         = 32;

    // Saturation points and 8.3 limits of the base, extension and length counters, prefix length
    localparam logic [BASE_W-1:0] BASE_SAT   = BASE_W'(9);
    localparam logic [BASE_W-1:0] BASE_MAX83 = BASE_W'(8);
    localparam logic [BASE_W-1:0] PREFIX_LEN = BASE_W'(4);
    localparam logic [EXT_W-1:0]  EXT_SAT    = EXT_W'(4);
    localparam logic [EXT_W-1:0]  EXT_MAX83  = EXT_W'(3);
    localparam int                SHORT_MAX  = 12;

    // (len + 12) / 13 done as multiply by 2^16/13, rounded up
    localparam int LFN_CHARS   = 13;
    localparam int LFN_ROUND   = LFN_CHARS - 1;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + LFN_CHARS - 1) / LFN_CHARS;
    localparam int PROD_W      = RECIP_SHIFT + ENT_W;

    // Queue between the classifier and the accumulator
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item opcodes
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } op_t;

    // Special bytes
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CH_W-1:0] CH_DIG1  = 8'h31;
    localparam logic [CH_W-1:0] CH_DIG9  = 8'h39;

    // Reserved device names, three upper-case letters packed
    localparam logic [23:0] RSV_CON = 24'h434F4E;
    localparam logic [23:0] RSV_PRN = 24'h50524E;
    localparam logic [23:0] RSV_AUX = 24'h415558;
    localparam logic [23:0] RSV_NUL = 24'h4E554C;
    localparam logic [23:0] RSV_COM = 24'h434F4D;
    localparam logic [23:0] RSV_LPT = 24'h4C5054;

    // Classified word passed from the front end to the back end
    typedef struct packed {
        op_t             op;
        logic            bad;        // control, high or forbidden byte
        logic            space;
        logic            short_char; // letter, digit, dot, underscore, dash
        logic            dot;
        logic [CH_W-1:0] ch_up;      // byte folded to upper case
    } cls_t;

    function automatic logic is_forbidden(input logic [CH_W-1:0] b);
        return (b == 8'h3C) || (b == 8'h3E) || (b == 8'h3A) || (b == 8'h22) ||
               (b == 8'h7C) || (b == 8'h3F) || (b == 8'h2A);
    endfunction

    function automatic logic is_lower(input logic [CH_W-1:0] b);
        return (b >= 8'h61) && (b <= 8'h7A);
    endfunction

    function automatic logic is_alnum(input logic [CH_W-1:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
               is_lower(b);
    endfunction

    function automatic logic [CH_W-1:0] fold_upper(input logic [CH_W-1:0] b);
        return is_lower(b) ? (b - 8'h20) : b;
    endfunction

endpackage

/* hw/rtl/fnc_in_if.sv */
// Input channel: one name byte or an end marker per word.
interface fnc_in_if;
    import fnc_pkg::*;

    logic            valid;
    logic            ready;
    logic            op;
    logic [CH_W-1:0] ch;

    modport source (output valid, output op, output ch, input ready);
    modport sink   (input valid, input op, input ch, output ready);
endinterface

/* hw/rtl/fnc_out_if.sv */
// Output channel: validity flag and directory entry count per name.
interface fnc_out_if;
    import fnc_pkg::*;

    logic             valid;
    logic             ready;
    logic             name_ok;
    logic [ENT_W-1:0] entry_count;

    modport source (output valid, output name_ok, output entry_count, input ready);
    modport sink   (input valid, input name_ok, input entry_count, output ready);
endinterface

/* hw/rtl/fnc_front.sv */
// Front end: accepts input words and classifies each byte into flags.
module fnc_front (
    input  logic          clk,
    input  logic          rst_n,
    fnc_in_if.sink        name_byte,
    output logic          cls_valid,
    output fnc_pkg::cls_t cls_word,
    input  logic          cls_ready
);
    import fnc_pkg::*;

    logic valid_reg;
    cls_t cls_reg;
    cls_t cls_next;
    logic take;

    assign name_byte.ready = !valid_reg || cls_ready;
    assign take            = name_byte.valid && name_byte.ready;

    // Classify the incoming byte
    always_comb
    begin
        cls_next.op         = op_t'(name_byte.op);
        cls_next.bad        = (name_byte.ch < CH_SPACE) || name_byte.ch[CH_W-1] ||
                              is_forbidden(name_byte.ch);
        cls_next.space      = (name_byte.ch == CH_SPACE);
        cls_next.short_char = (name_byte.ch == CH_DOT) || (name_byte.ch == CH_UNDER) ||
                              (name_byte.ch == CH_DASH) || is_alnum(name_byte.ch);
        cls_next.dot        = (name_byte.ch == CH_DOT);
        cls_next.ch_up      = fold_upper(name_byte.ch);
    end

    // Valid flag of the classifier stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (name_byte.ready)
        begin
            valid_reg <= name_byte.valid;
        end
    end

    // Classified payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls_word  = cls_reg;
endmodule

/* hw/rtl/fnc_queue.sv */
// Short FIFO of classified words between front end and back end.
module fnc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    input  fnc_pkg::cls_t wr_word,
    output logic          wr_ready,
    output logic          rd_valid,
    output fnc_pkg::cls_t rd_word,
    input  logic          rd_ready
);
    import fnc_pkg::*;

    cls_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_word  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_word;
        end
    end
endmodule

/* hw/rtl/fnc_back.sv */
// Back end: accumulates per-name state and produces the result word.
module fnc_back #(
    parameter int MAX_NAME_LEN = fnc_pkg::MAX_NAME_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cls_valid,
    input  fnc_pkg::cls_t cls_word,
    output logic          cls_ready,
    fnc_out_if.source     result
);
    import fnc_pkg::*;

    localparam int LEN_W = $clog2(MAX_NAME_LEN + 2);
    localparam int X_W   = $clog2(MAX_NAME_LEN + 1 + LFN_ROUND + 1);

    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic                dot_reg;
    logic                dot_next;
    logic [BASE_W-1:0]   base_reg;
    logic [BASE_W-1:0]   base_next;
    logic [EXT_W-1:0]    ext_reg;
    logic [EXT_W-1:0]    ext_next;
    logic [PREFIX_W-1:0] prefix_reg;
    logic [PREFIX_W-1:0] prefix_next;
    logic                bad_reg;
    logic                bad_next;
    logic                space_reg;
    logic                space_next;
    logic                short_reg;
    logic                short_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                ok_reg;
    logic                ok_next;
    logic [ENT_W-1:0]    ent_reg;
    logic [ENT_W-1:0]    ent_next;

    logic                take;
    logic                is_end;
    logic                reserved;
    logic                short_ok;
    logic [X_W-1:0]      lfn_x;
    logic [PROD_W-1:0]   lfn_prod;
    logic [ENT_W-1:0]    lfn_q;

    assign is_end    = (cls_word.op == OP_END);
    assign cls_ready = !is_end || !out_valid_reg || result.ready;
    assign take      = cls_valid && cls_ready;

    // Reserved device name match on the base name
    always_comb
    begin
        reserved = 1'b0;
        if (base_reg == BASE_W'(3))
        begin
            reserved = (prefix_reg[23:0] == RSV_CON) || (prefix_reg[23:0] == RSV_PRN) ||
                       (prefix_reg[23:0] == RSV_AUX) || (prefix_reg[23:0] == RSV_NUL);
        end
        else if (base_reg == BASE_W'(4))
        begin
            reserved = (prefix_reg[7:0] >= CH_DIG1) && (prefix_reg[7:0] <= CH_DIG9) &&
                       ((prefix_reg[31:8] == RSV_COM) || (prefix_reg[31:8] == RSV_LPT));
        end
    end

    // Entry count: 1 for 8.3, else ceil(len/13) + 1 via reciprocal multiply
    assign short_ok = (len_reg <= LEN_W'(SHORT_MAX)) && !space_reg && short_reg &&
                      (!dot_reg || ((base_reg <= BASE_MAX83) && (ext_reg <= EXT_MAX83)));
    assign lfn_x    = X_W'(len_reg) + X_W'(LFN_ROUND);
    assign lfn_prod = PROD_W'(lfn_x) * PROD_W'(RECIP);
    assign lfn_q    = lfn_prod[RECIP_SHIFT +: ENT_W];

    // Next state of the accumulator and the result register
    always_comb
    begin
        len_next       = len_reg;
        dot_next       = dot_reg;
        base_next      = base_reg;
        ext_next       = ext_reg;
        prefix_next    = prefix_reg;
        bad_next       = bad_reg;
        space_next     = space_reg;
        short_next     = short_reg;
        out_valid_next = out_valid_reg && !result.ready;
        ok_next        = ok_reg;
        ent_next       = ent_reg;

        if (take && is_end)
        begin
            out_valid_next = 1'b1;
            ok_next        = (len_reg != '0) && (len_reg <= LEN_W'(MAX_NAME_LEN)) &&
                             !bad_reg && !reserved;
            ent_next       = short_ok ? ENT_W'(1) : lfn_q + 1'b1;
            len_next       = '0;
            dot_next       = 1'b0;
            base_next      = '0;
            ext_next       = '0;
            prefix_next    = '0;
            bad_next       = 1'b0;
            space_next     = 1'b0;
            short_next     = 1'b1;
        end
        else if (take)
        begin
            if (len_reg != LEN_W'(MAX_NAME_LEN + 1))
            begin
                len_next = len_reg + 1'b1;
            end
            bad_next   = bad_reg || cls_word.bad;
            space_next = space_reg || cls_word.space;
            short_next = short_reg && cls_word.short_char;
            if (dot_reg)
            begin
                if (ext_reg != EXT_SAT)
                begin
                    ext_next = ext_reg + 1'b1;
                end
            end
            else if (cls_word.dot)
            begin
                dot_next = 1'b1;
            end
            else
            begin
                if (base_reg < PREFIX_LEN)
                begin
                    prefix_next = {prefix_reg[PREFIX_W-CH_W-1:0], cls_word.ch_up};
                end
                if (base_reg != BASE_SAT)
                begin
                    base_next = base_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            dot_reg       <= 1'b0;
            base_reg      <= '0;
            ext_reg       <= '0;
            prefix_reg    <= '0;
            bad_reg       <= 1'b0;
            space_reg     <= 1'b0;
            short_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            dot_reg       <= dot_next;
            base_reg      <= base_next;
            ext_reg       <= ext_next;
            prefix_reg    <= prefix_next;
            bad_reg       <= bad_next;
            space_reg     <= space_next;
            short_reg     <= short_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        ok_reg  <= ok_next;
        ent_reg <= ent_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.name_ok     = ok_reg;
    assign result.entry_count = ent_reg;
endmodule

/* hw/rtl/fat_filename_check_and_entry_count.sv */
// Top level: FAT long file name checker and directory entry counter.
//
// A name arrives one byte per word on name_byte (op = byte), closed by an end
// word (op = end); the end word yields one word on result with the validity
// flag and the number of directory entries the name needs. A register stage
// classifies the byte, a two-entry queue decouples it from the accumulator, and
// the accumulator updates counters and flags for one word per cycle while no end
// word waits. An accepted end word passes the classifier register and the queue,
// and its result sits in an output register; only an end word that meets a full
// output register waits, and the words behind it back up. The entry count uses
// one small constant multiply ahead of the output register.
module fat_filename_check_and_entry_count #(
    parameter int MAX_NAME_LEN = fnc_pkg::MAX_NAME_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fnc_in_if.sink    name_byte,
    fnc_out_if.source result
);
    import fnc_pkg::*;

    logic cls_valid;
    cls_t cls_word;
    logic cls_ready;
    logic q_valid;
    cls_t q_word;
    logic q_ready;

    // Byte classifier
    fnc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .name_byte (name_byte),
        .cls_valid (cls_valid),
        .cls_word  (cls_word),
        .cls_ready (cls_ready)
    );

    // Decoupling queue
    fnc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cls_valid),
        .wr_word  (cls_word),
        .wr_ready (cls_ready),
        .rd_valid (q_valid),
        .rd_word  (q_word),
        .rd_ready (q_ready)
    );

    // Accumulator and result register
    fnc_back #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_word  (q_word),
        .cls_ready (q_ready),
        .result    (result)
    );
endmodule

/* sim/fat_filename_check_and_entry_count_tb.sv */
// Testbench for the FAT file name checker: streams names, predicts verdicts, checks results.
`timescale 1ns / 100ps

module fat_filename_check_and_entry_count_tb;
    import fnc_pkg::*;

    localparam int NAME_MAX     = 255;
    localparam int ITEM_TARGET  = 1550;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 10;
    localparam int CLK_HALF     = 10;

    typedef logic [CH_W-1:0] name_q_t[$];

    // One expected result word
    typedef struct packed {
        logic             name_ok;
        logic [ENT_W-1:0] entries;
    } verdict_t;

    logic clk;
    logic rst_n;

    fnc_in_if  name_byte_if ();
    fnc_out_if result_if ();

    fat_filename_check_and_entry_count #(
        .MAX_NAME_LEN (NAME_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .name_byte (name_byte_if.sink),
        .result    (result_if.source)
    );

    verdict_t verdict_q[$];
    int       fail_count;
    int       words_sent;
    int       names_sent;
    int       results_seen;
    int       input_stall_cycles;
    int       hold_req;
    bit       no_idle;

    // Running view of the name being received
    logic [8:0]          seen_len;
    logic                dot_hit;
    logic [BASE_W-1:0]   stem_len;
    logic [EXT_W-1:0]    ext_chars;
    logic [PREFIX_W-1:0] stem_head;
    logic                has_bad;
    logic                has_space;
    logic                only_short;

    // Clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Watchdog
    initial
    begin
        #(20_000_000);
        $display("status: fail");
        $finish;
    end

    function automatic void clear_name_state();
        seen_len   = '0;
        dot_hit    = 1'b0;
        stem_len   = '0;
        ext_chars  = '0;
        stem_head  = '0;
        has_bad    = 1'b0;
        has_space  = 1'b0;
        only_short = 1'b1;
    endfunction

    function automatic logic [CH_W-1:0] upcase(input logic [CH_W-1:0] b);
        if (b >= "a" && b <= "z")
            return b - 8'd32;
        return b;
    endfunction

    // Device names: three letters, or COM/LPT plus a digit 1..9
    function automatic logic device_name();
        if (stem_len == 4'd3)
            return stem_head[23:0] == "CON" || stem_head[23:0] == "PRN" ||
                   stem_head[23:0] == "AUX" || stem_head[23:0] == "NUL";
        if (stem_len == 4'd4)
            return stem_head[7:0] >= "1" && stem_head[7:0] <= "9" &&
                   (stem_head[31:8] == "COM" || stem_head[31:8] == "LPT");
        return 1'b0;
    endfunction

    // Fold one accepted word into the name state; an end word yields a verdict
    function automatic void track_word(input op_t op, input logic [CH_W-1:0] b);
        verdict_t v;
        logic     plain83;
        logic     is_letter_digit;
        if (op == OP_BYTE)
        begin
            if (seen_len < 9'(NAME_MAX + 1))
                seen_len = seen_len + 9'd1;
            if (b < 8'd32 || b >= 8'd128 || b == "<" || b == ">" || b == ":" ||
                b == "\"" || b == "|" || b == "?" || b == "*")
                has_bad = 1'b1;
            if (b == " ")
                has_space = 1'b1;
            is_letter_digit = (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
                              (b >= "a" && b <= "z");
            if (!(is_letter_digit || b == "." || b == "_" || b == "-"))
                only_short = 1'b0;
            if (dot_hit)
            begin
                if (ext_chars < 3'd4)
                    ext_chars = ext_chars + 3'd1;
            end
            else if (b == ".")
                dot_hit = 1'b1;
            else
            begin
                if (stem_len < 4'd4)
                    stem_head = {stem_head[23:0], upcase(b)};
                if (stem_len < 4'd9)
                    stem_len = stem_len + 4'd1;
            end
            return;
        end
        v.name_ok = seen_len != 0 && seen_len <= 9'(NAME_MAX) && !has_bad && !device_name();
        plain83 = seen_len <= 9'd12 && !has_space && only_short &&
                  (!dot_hit || (stem_len <= 4'd8 && ext_chars <= 3'd3));
        v.entries = plain83 ? ENT_W'(1) : ENT_W'((int'(seen_len) + 12) / 13 + 1);
        verdict_q.push_back(v);
        clear_name_state();
    endfunction

    // Input monitor: predicts on every accepted word
    always @(posedge clk)
    begin
        if (rst_n && name_byte_if.valid)
        begin
            if (name_byte_if.ready)
                track_word(op_t'(name_byte_if.op), name_byte_if.ch);
            else
                input_stall_cycles++;
        end
    end

    // Result checker: compare each accepted result with the oldest verdict
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_seen++;
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result word: name_ok=%0d entry_count=%0d",
                       result_if.name_ok, result_if.entry_count);
                fail_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (result_if.name_ok !== want.name_ok)
                begin
                    $error("name_ok: expected %0d, actual %0d", want.name_ok,
                           result_if.name_ok);
                    fail_count++;
                end
                if (result_if.entry_count !== want.entries)
                begin
                    $error("entry_count: expected %0d, actual %0d", want.entries,
                           result_if.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Result sink: random stalls, plus long hold-offs on request
    initial
    begin : result_sink
        int n;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req != 0)
            begin
                n = hold_req;
                hold_req = 0;
                result_if.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = no_idle ? 0 : idle_len();
                if (n == 0)
                begin
                    result_if.ready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    result_if.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // Offer one word and wait until it is taken; entered and left on a rising edge
    task automatic put_word(input op_t op, input logic [CH_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0)
        begin
            name_byte_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        name_byte_if.valid <= 1'b1;
        name_byte_if.op    <= op;
        name_byte_if.ch    <= b;
        @(posedge clk);
        while (!name_byte_if.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic put_name(input name_q_t name);
        foreach (name[i])
            put_word(OP_BYTE, name[i]);
        put_word(OP_END, CH_W'($urandom_range(255)));
        names_sent++;
    endtask

    task automatic put_text(input string s);
        name_q_t name;
        for (int i = 0; i < s.len(); i++)
            name.push_back(s[i]);
        put_name(name);
    endtask

    // Sender pause: stop offering until every verdict has been matched
    task automatic wait_results_done();
        int waited;
        waited = 0;
        name_byte_if.valid <= 1'b0;
        while (verdict_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (verdict_q.size() != 0)
        begin
            $error("%0d expected result words never arrived", verdict_q.size());
            fail_count++;
            verdict_q.delete();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CH_W-1:0] pick_short(input bit allow_dot);
        int r;
        r = $urandom_range(65);
        if (r < 26)
            return CH_W'("A" + r);
        if (r < 52)
            return CH_W'("a" + r - 26);
        if (r < 62)
            return CH_W'("0" + r - 52);
        if (r == 62)
            return "_";
        if (r == 63)
            return "-";
        return allow_dot ? CH_DOT : CH_W'("Z");
    endfunction

    // Random name of one of several shapes
    function automatic name_q_t make_name();
        name_q_t name;
        string   dev;
        int      kind;
        int      n;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            // 8.3-like, sometimes just over the limits
            n = $urandom_range(9, 1);
            repeat (n) name.push_back(pick_short(1'b0));
            if ($urandom_range(3) != 0)
            begin
                name.push_back(CH_DOT);
                n = $urandom_range(4);
                repeat (n) name.push_back(pick_short($urandom_range(7) == 0));
            end
        end
        else if (kind < 60)
        begin
            // device names in mixed case, with near misses
            case ($urandom_range(5))
                0: dev = "CON";
                1: dev = "PRN";
                2: dev = "AUX";
                3: dev = "NUL";
                4: dev = "COM";
                default: dev = "LPT";
            endcase
            for (int i = 0; i < 3; i++)
                name.push_back($urandom_range(1) ? dev[i] : dev[i] | 8'h20);
            if (dev == "COM" || dev == "LPT" || $urandom_range(9) == 0)
                name.push_back(CH_W'("0" + $urandom_range(9)));
            if ($urandom_range(6) == 0)
                name.push_back(pick_short(1'b0));
            if ($urandom_range(2) == 0)
            begin
                name.push_back(CH_DOT);
                n = $urandom_range(3);
                repeat (n) name.push_back(pick_short(1'b1));
            end
        end
        else if (kind < 85)
        begin
            // long names of printable bytes, rarely near the length limit
            n = ($urandom_range(29) == 0) ? $urandom_range(NAME_MAX + 5, 240)
                                          : $urandom_range(40, 1);
            repeat (n)
                name.push_back(($urandom_range(2) == 0) ? CH_W'($urandom_range(126, 32))
                                                        : pick_short(1'b1));
        end
        else if (kind < 96)
        begin
            // raw bytes over the whole range
            n = $urandom_range(20);
            repeat (n) name.push_back(CH_W'($urandom_range(255)));
        end
        return name;
    endfunction

    // Edge cases, one name each
    task automatic test_directed();
        name_q_t name;
        string   forbidden;
        forbidden = "<>:\"|?*";
        put_text("");
        put_text("A");
        put_text("FILENAME.TXT");
        put_text("FILENAME9.TXT");
        put_text("readme.text");
        put_text("a.b.c");
        put_text("ABCDEFGHIJKL");
        put_text("ABCDEFGHIJKLM");
        put_text("_-0.z9");
        put_text("CON");
        put_text("con.txt");
        put_text("Com1");
        put_text("lpt9.log");
        put_text("COM0");
        put_text("CONX");
        put_text("AUX.");
        put_text("my file");
        for (int i = 0; i < forbidden.len(); i++)
            put_text({"a", forbidden.substr(i, i)});
        put_name('{8'h00});
        put_name('{"A", 8'h1F, 8'h7F});
        put_name('{8'h80, 8'hFF});
        // exactly at the length limit, then one past it
        name.delete();
        repeat (NAME_MAX) name.push_back("x");
        put_name(name);
        name.push_back("y");
        put_name(name);
        wait_results_done();
    endtask

    // Bulk random names with stretches of no idling
    task automatic test_random_names();
        int batch;
        batch = 0;
        while (words_sent < ITEM_TARGET - 360)
        begin
            if (batch % 40 == 0)
                no_idle = ($urandom_range(3) == 0);
            put_name(make_name());
            batch++;
        end
        no_idle = 1'b0;
        wait_results_done();
    endtask

    // Receiver holds off while short names keep coming, so the input backs up
    task automatic test_output_holdoff();
        no_idle = 1'b1;
        hold_req = HOLD_CYCLES;
        repeat (24) put_text("AB.C");
        no_idle = 1'b0;
        wait_results_done();
    endtask

    // Sender stops several times until every result is back
    task automatic test_drain_pause();
        repeat (6)
        begin
            repeat ($urandom_range(5, 1)) put_name(make_name());
            wait_results_done();
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n <= 1'b0;
        name_byte_if.valid <= 1'b0;
        name_byte_if.op    <= OP_BYTE;
        name_byte_if.ch    <= '0;
        clear_name_state();
        fail_count = 0;
        words_sent = 0;
        names_sent = 0;
        results_seen = 0;
        input_stall_cycles = 0;
        hold_req = 0;
        no_idle = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_holdoff();
        test_random_names();
        test_drain_pause();
        test_output_holdoff();
        wait_results_done();

        $display("ran %0d names in %0d words, checked %0d results", names_sent,
                 words_sent, results_seen);
        $display("input backed up for %0d cycles under output hold-off and stalls",
                 input_stall_cycles);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
